// File: hw/rtl/rlhm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radio link health monitor package
// Event codes, configuration register indexes and field widths that are
// shared by the monitor and its checker.
// ----------------------------------------------------------------------------
package rlhm_pkg;

    localparam int COUNT_W  = 16;
    localparam int STAMP_W  = 32;
    localparam int WINDOW_W = 16;
    localparam int THRESH_W = 9;
    localparam int TOTAL_W  = COUNT_W + 1;
    localparam int SCALED_W = COUNT_W + 8;
    localparam int PROD_W   = THRESH_W + TOTAL_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [1:0] {
        ACT_TX_SUCCESS = 2'd0,
        ACT_TX_FAILURE = 2'd1,
        ACT_STATUS     = 2'd2,
        ACT_QUALITY    = 2'd3
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LINK_ENABLED   = 3'd0,
        REG_SUCCESS_WINDOW = 3'd1,
        REG_FAILURE_WINDOW = 3'd2,
        REG_STATUS_THRESH  = 3'd3,
        REG_QUALITY_THRESH = 3'd4
    } cfg_index_t;

    localparam logic [WINDOW_W-1:0] SUCCESS_WINDOW_RST = 16'd2000;
    localparam logic [WINDOW_W-1:0] FAILURE_WINDOW_RST = 16'd1000;
    localparam logic [THRESH_W-1:0] STATUS_THRESH_RST  = 9'd128;
    localparam logic [THRESH_W-1:0] QUALITY_THRESH_RST = 9'd179;
    localparam logic [COUNT_W-1:0]  COUNT_MAX          = '1;

endpackage

// File: hw/rtl/radio_link_health_monitor_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radio link health monitor
// Counts transmit outcomes, keeps the link-good flag and status LED level,
// and answers link quality checks, one event per cycle unless the output stalls.
// ----------------------------------------------------------------------------
// Events arrive on the input channel (in_valid, in_stall, action, now_ms) and
// each produces exactly one result transaction on the output channel
// (out_valid, out_stall and the result fields).
// An accepted event is held in the input register; the counters, the two age
// comparisons and the 9 x 17 bit rate multiply then update the state and load
// the result register, which drives the output, once that register is free.
// One event is taken in every cycle while the receiver does not stall.
// When the receiver stalls, the result register holds its transaction and the
// input register can still take one more event; in_stall rises only when both
// are full.
// Configuration is written through cfg_we, cfg_index and cfg_data; the user must
// write it only while the block is idle (the block does not enforce this), and
// writes to unknown indexes are ignored. Reset clears the counters, stamps,
// flags and both registers and loads the default configuration (link disabled).
// ----------------------------------------------------------------------------
module radio_link_health_monitor_unit
    import rlhm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            action,
    input  logic [STAMP_W-1:0]    now_ms,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  link_healthy,
    output logic                  led_level,
    output logic                  quality_ok,
    output logic [COUNT_W-1:0]    successes,
    output logic [COUNT_W-1:0]    failures
);

    logic                link_enabled_reg;
    logic [WINDOW_W-1:0] success_window_reg;
    logic [WINDOW_W-1:0] failure_window_reg;
    logic [THRESH_W-1:0] status_thresh_reg;
    logic [THRESH_W-1:0] quality_thresh_reg;

    logic [COUNT_W-1:0]  success_total_reg, success_total_next;
    logic [COUNT_W-1:0]  failure_total_reg, failure_total_next;
    logic [STAMP_W-1:0]  success_stamp_reg, success_stamp_next;
    logic [STAMP_W-1:0]  failure_stamp_reg, failure_stamp_next;
    logic                good_flag_reg, good_flag_next;
    logic                blink_reg, blink_next;
    logic                led_reg, led_next;
    logic                quality_next;

    logic                in_valid_reg;
    action_t             in_action_reg;
    logic [STAMP_W-1:0]  in_now_reg;

    logic                out_valid_reg;
    logic                out_good_reg;
    logic                out_led_reg;
    logic                out_quality_reg;
    logic [COUNT_W-1:0]  out_successes_reg;
    logic [COUNT_W-1:0]  out_failures_reg;

    logic                out_load;
    logic                in_load;
    logic [STAMP_W-1:0]  success_age;
    logic [STAMP_W-1:0]  failure_age;
    logic                success_recent;
    logic                failure_recent;
    logic [TOTAL_W-1:0]  rate_total;
    logic [SCALED_W-1:0] scaled_successes;
    logic [PROD_W-1:0]   status_product;
    logic [PROD_W-1:0]   quality_product;
    logic                status_rate_ok;
    logic                quality_rate_ok;

    assign out_load = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_load  = in_valid && !in_stall;
    assign in_stall = in_valid_reg && !out_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_enabled_reg   <= 1'b0;
            success_window_reg <= SUCCESS_WINDOW_RST;
            failure_window_reg <= FAILURE_WINDOW_RST;
            status_thresh_reg  <= STATUS_THRESH_RST;
            quality_thresh_reg <= QUALITY_THRESH_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_LINK_ENABLED:   link_enabled_reg   <= cfg_data[0];
                REG_SUCCESS_WINDOW: success_window_reg <= cfg_data[WINDOW_W-1:0];
                REG_FAILURE_WINDOW: failure_window_reg <= cfg_data[WINDOW_W-1:0];
                REG_STATUS_THRESH:  status_thresh_reg  <= cfg_data[THRESH_W-1:0];
                REG_QUALITY_THRESH: quality_thresh_reg <= cfg_data[THRESH_W-1:0];
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_load)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (out_load)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_action_reg <= action_t'(action);
            in_now_reg    <= now_ms;
        end
    end

    assign success_age      = in_now_reg - success_stamp_reg;
    assign failure_age      = in_now_reg - failure_stamp_reg;
    assign success_recent   = success_age < {{(STAMP_W-WINDOW_W){1'b0}}, success_window_reg};
    assign failure_recent   = failure_age < {{(STAMP_W-WINDOW_W){1'b0}}, failure_window_reg};
    assign rate_total       = {1'b0, success_total_reg} + {1'b0, failure_total_reg};
    assign scaled_successes = {success_total_reg, 8'd0};
    assign status_product   = PROD_W'(status_thresh_reg) * PROD_W'(rate_total);
    assign quality_product  = PROD_W'(quality_thresh_reg) * PROD_W'(rate_total);
    assign status_rate_ok   = PROD_W'(scaled_successes) > status_product;
    assign quality_rate_ok  = PROD_W'(scaled_successes) > quality_product;

    always_comb
    begin
        success_total_next = success_total_reg;
        failure_total_next = failure_total_reg;
        success_stamp_next = success_stamp_reg;
        failure_stamp_next = failure_stamp_reg;
        good_flag_next     = good_flag_reg;
        blink_next         = blink_reg;
        led_next           = led_reg;
        quality_next       = 1'b0;
        case (in_action_reg)
            ACT_TX_SUCCESS:
            begin
                if (link_enabled_reg)
                begin
                    if (success_total_reg != COUNT_MAX)
                    begin
                        success_total_next = success_total_reg + 1'b1;
                    end
                    success_stamp_next = in_now_reg;
                end
            end
            ACT_TX_FAILURE:
            begin
                if (link_enabled_reg)
                begin
                    if (failure_total_reg != COUNT_MAX)
                    begin
                        failure_total_next = failure_total_reg + 1'b1;
                    end
                    failure_stamp_next = in_now_reg;
                end
            end
            ACT_STATUS:
            begin
                if (!link_enabled_reg)
                begin
                    led_next = 1'b0;
                end
                else
                begin
                    good_flag_next = (success_total_reg != '0) && status_rate_ok
                                     && success_recent;
                    if (good_flag_next)
                    begin
                        led_next = 1'b1;
                    end
                    else if (failure_recent)
                    begin
                        blink_next = !blink_reg;
                        led_next   = !blink_reg;
                    end
                    else
                    begin
                        led_next = 1'b0;
                    end
                end
            end
            ACT_QUALITY:
            begin
                quality_next = link_enabled_reg && (success_total_reg != '0)
                               && quality_rate_ok && success_recent;
            end
            default:
            begin
                quality_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            success_total_reg <= '0;
            failure_total_reg <= '0;
            success_stamp_reg <= '0;
            failure_stamp_reg <= '0;
            good_flag_reg     <= 1'b0;
            blink_reg         <= 1'b0;
            led_reg           <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                success_total_reg <= success_total_next;
                failure_total_reg <= failure_total_next;
                success_stamp_reg <= success_stamp_next;
                failure_stamp_reg <= failure_stamp_next;
                good_flag_reg     <= good_flag_next;
                blink_reg         <= blink_next;
                led_reg           <= led_next;
                out_valid_reg     <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_good_reg      <= good_flag_next;
            out_led_reg       <= led_next;
            out_quality_reg   <= quality_next;
            out_successes_reg <= success_total_next;
            out_failures_reg  <= failure_total_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign link_healthy = out_good_reg;
    assign led_level    = out_led_reg;
    assign quality_ok   = out_quality_reg;
    assign successes    = out_successes_reg;
    assign failures     = out_failures_reg;

endmodule

// File: hw/rtl/rlhm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radio link health monitor checker
// Port-level assertions on the result channel, bound to the monitor.
// ----------------------------------------------------------------------------
module rlhm_checker
    import rlhm_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  out_valid,
    input logic                  out_stall,
    input logic                  link_healthy,
    input logic                  quality_ok,
    input logic [COUNT_W-1:0]    successes,
    input logic [COUNT_W-1:0]    failures
);

    // A stalled result transaction stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result transaction withdrawn while stalled");

    // A stalled result transaction keeps its counters.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(successes) && $stable(failures))
        else $error("result counters changed while stalled");

    // The link can only be reported good once a success has been counted.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && link_healthy |-> successes != '0)
        else $error("link good reported with no success counted");

    // A positive quality answer also needs a counted success.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && quality_ok |-> successes != '0)
        else $error("quality reported good with no success counted");

endmodule

bind radio_link_health_monitor_unit rlhm_checker u_rlhm_checker (.*);

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radio link health monitor testbench
// Drives timestamped link events into the monitor and checks every result
// transaction against a cycle-free model of the counters, the link-good flag,
// the LED blink logic and the quality answer. Directed events cover timestamp
// wrap, window edges and rate-equality cases; random phases vary the
// configuration between its extremes while both channels idle at random, one
// phase holds the output off long enough to back up the input, and a final
// phase runs with no idling on either side.
// ----------------------------------------------------------------------------
module testbench;
    import rlhm_pkg::*;

    localparam int HOLD_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_EVENTS = 240;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = CFG_IDX_W'(REG_QUALITY_THRESH + 1);

    typedef struct {
        action_t   act;
        bit [31:0] stamp;
    } link_event_t;

    typedef struct {
        bit         link_healthy;
        bit         led;
        bit         quality;
        bit [15:0]  succ;
        bit [15:0]  fail;
    } health_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [1:0]            action = ACT_TX_SUCCESS;
    logic [STAMP_W-1:0]    now_ms = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  link_healthy;
    logic                  led_level;
    logic                  quality_ok;
    logic [COUNT_W-1:0]    successes;
    logic [COUNT_W-1:0]    failures;

    link_event_t event_backlog[$];
    health_t     expected_reports[$];

    bit        link_on = 1'b0;
    bit [15:0] succ_window = SUCCESS_WINDOW_RST;
    bit [15:0] fail_window = FAILURE_WINDOW_RST;
    bit [8:0]  status_thr = STATUS_THRESH_RST;
    bit [8:0]  quality_thr = QUALITY_THRESH_RST;

    bit [15:0] succ_cnt = '0;
    bit [15:0] fail_cnt = '0;
    bit [31:0] succ_stamp = '0;
    bit [31:0] fail_stamp = '0;
    bit        good_q = 1'b0;
    bit        blink_q = 1'b0;
    bit        led_q = 1'b0;

    bit calm = 1'b0;
    bit hold_request = 1'b0;
    int events_accepted = 0;
    int results_checked = 0;
    int settings_count = 0;
    int fault_count = 0;
    int idle_cycles = 0;

    radio_link_health_monitor_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .now_ms       (now_ms),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .link_healthy (link_healthy),
        .led_level    (led_level),
        .quality_ok   (quality_ok),
        .successes    (successes),
        .failures     (failures)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic bit rate_exceeds(input bit [8:0] thr);
        bit [16:0] total;
        bit [24:0] scaled;
        bit [25:0] bound;
        total = succ_cnt + fail_cnt;
        scaled = {succ_cnt, 8'd0};
        bound = thr * total;
        return scaled > bound;
    endfunction

    task automatic predict_link_health(input action_t act, input bit [31:0] now);
        health_t   r;
        bit [31:0] succ_age;
        bit [31:0] fail_age;
        bit        succ_recent;
        bit        fail_recent;
        succ_age = now - succ_stamp;
        fail_age = now - fail_stamp;
        succ_recent = succ_age < {16'd0, succ_window};
        fail_recent = fail_age < {16'd0, fail_window};
        r.quality = 1'b0;
        case (act)
            ACT_TX_SUCCESS:
            begin
                if (link_on)
                begin
                    if (succ_cnt != COUNT_MAX)
                        succ_cnt++;
                    succ_stamp = now;
                end
            end
            ACT_TX_FAILURE:
            begin
                if (link_on)
                begin
                    if (fail_cnt != COUNT_MAX)
                        fail_cnt++;
                    fail_stamp = now;
                end
            end
            ACT_STATUS:
            begin
                if (!link_on)
                    led_q = 1'b0;
                else
                begin
                    good_q = (succ_cnt != 0) && rate_exceeds(status_thr) && succ_recent;
                    if (good_q)
                        led_q = 1'b1;
                    else if (fail_recent)
                    begin
                        blink_q = !blink_q;
                        led_q = blink_q;
                    end
                    else
                        led_q = 1'b0;
                end
            end
            default:
            begin
                if (link_on && succ_cnt != 0)
                    r.quality = rate_exceeds(quality_thr) && succ_recent;
            end
        endcase
        r.link_healthy = good_q;
        r.led = led_q;
        r.succ = succ_cnt;
        r.fail = fail_cnt;
        expected_reports.push_back(r);
    endtask

    // Sender: holds a stalled transaction, otherwise idles or offers the next event.
    always @(posedge clk)
    begin : drive_proc
        static int tx_gap = 0;
        static int tx_cycle = 0;
        static bit tx_quiet = 1'b0;
        link_event_t nxt;
        if (rst_n)
        begin
            tx_cycle++;
            if (tx_cycle % 64 == 0)
                tx_quiet = ($urandom_range(0, 2) == 0);
            if (in_valid && !in_stall)
            begin
                predict_link_health(action_t'(action), now_ms);
                events_accepted++;
            end
            if (!in_valid || !in_stall)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap--;
                    in_valid <= 1'b0;
                end
                else if (event_backlog.size() == 0)
                    in_valid <= 1'b0;
                else if (!calm && !tx_quiet && $urandom_range(0, 9) == 0)
                begin
                    tx_gap = $urandom_range(1, 12) - 1;
                    in_valid <= 1'b0;
                end
                else
                begin
                    nxt = event_backlog.pop_front();
                    in_valid <= 1'b1;
                    action <= nxt.act;
                    now_ms <= nxt.stamp;
                end
            end
        end
    end

    // Receiver: checks each result transaction and decides the next stall.
    always @(posedge clk)
    begin : check_proc
        static int rx_gap = 0;
        static int rx_cycle = 0;
        static int hold_left = 0;
        static bit rx_quiet = 1'b0;
        health_t want;
        if (rst_n)
        begin
            rx_cycle++;
            if (rx_cycle % 64 == 0)
                rx_quiet = ($urandom_range(0, 2) == 0);
            if (out_valid && !out_stall)
            begin
                results_checked++;
                if (expected_reports.size() == 0)
                begin
                    $error("result transaction with no event outstanding");
                    fault_count++;
                end
                else
                begin
                    want = expected_reports.pop_front();
                    if (link_healthy !== want.link_healthy)
                    begin
                        $error("link_healthy: expected %0d, got %0d",
                               want.link_healthy, link_healthy);
                        fault_count++;
                    end
                    if (led_level !== want.led)
                    begin
                        $error("led_level: expected %0d, got %0d", want.led, led_level);
                        fault_count++;
                    end
                    if (quality_ok !== want.quality)
                    begin
                        $error("quality_ok: expected %0d, got %0d", want.quality, quality_ok);
                        fault_count++;
                    end
                    if (successes !== want.succ)
                    begin
                        $error("successes: expected %0d, got %0d", want.succ, successes);
                        fault_count++;
                    end
                    if (failures !== want.fail)
                    begin
                        $error("failures: expected %0d, got %0d", want.fail, failures);
                        fault_count++;
                    end
                end
            end
            if (hold_request)
            begin
                hold_left = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (rx_gap > 0)
            begin
                rx_gap--;
                out_stall <= 1'b1;
            end
            else if (!calm && !rx_quiet && $urandom_range(0, 9) == 0)
            begin
                rx_gap = $urandom_range(1, 12) - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic queue_event(input action_t act, input bit [31:0] stamp);
        link_event_t e;
        e.act = act;
        e.stamp = stamp;
        event_backlog.push_back(e);
    endtask

    task automatic drain;
        do
            @(negedge clk);
        while (event_backlog.size() != 0 || in_valid || expected_reports.size() != 0);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        case (idx)
            REG_LINK_ENABLED:   link_on = data[0];
            REG_SUCCESS_WINDOW: succ_window = data;
            REG_FAILURE_WINDOW: fail_window = data;
            REG_STATUS_THRESH:  status_thr = data[8:0];
            REG_QUALITY_THRESH: quality_thr = data[8:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input bit en, input bit [15:0] sw, input bit [15:0] fw,
                              input bit [8:0] st, input bit [8:0] qt);
        logic [CFG_DATA_W-1:0] d;
        @(posedge clk);
        d = CFG_DATA_W'($urandom);
        d[0] = en;
        cfg_write(REG_LINK_ENABLED, d);
        cfg_write(REG_SUCCESS_WINDOW, sw);
        cfg_write(REG_FAILURE_WINDOW, fw);
        d = CFG_DATA_W'($urandom);
        d[8:0] = st;
        cfg_write(REG_STATUS_THRESH, d);
        d = CFG_DATA_W'($urandom);
        d[8:0] = qt;
        cfg_write(REG_QUALITY_THRESH, d);
        cfg_write(REG_FIRST_UNUSED + CFG_IDX_W'($urandom_range(0, 2)),
                  CFG_DATA_W'($urandom));
        cfg_we <= 1'b0;
        @(negedge clk);
        settings_count++;
    endtask

    function automatic bit [15:0] pick_window();
        case ($urandom_range(0, 5))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'd1;
            default: return 16'($urandom_range(200, 3000));
        endcase
    endfunction

    function automatic bit [8:0] pick_threshold();
        case ($urandom_range(0, 6))
            0: return 9'd0;
            1: return 9'd256;
            2: return 9'h1FF;
            3: return 9'd257;
            default: return 9'($urandom_range(1, 255));
        endcase
    endfunction

    task automatic random_phase(input bit en, input bit [15:0] sw, input bit [15:0] fw,
                                input bit [8:0] st, input bit [8:0] qt,
                                input bit with_hold);
        bit [31:0] t;
        int        succ_pct;
        int        r;
        action_t   act;
        set_config(en, sw, fw, st, qt);
        if (with_hold)
            hold_request = 1'b1;
        t = $urandom;
        succ_pct = int'(st) * 100 / 256 + int'($urandom_range(0, 20)) - 10;
        if (succ_pct < 5)
            succ_pct = 5;
        if (succ_pct > 95)
            succ_pct = 95;
        for (int i = 0; i < PHASE_EVENTS; i++)
        begin
            r = $urandom_range(0, 9);
            if (r < 6)
                t += $urandom_range(0, 400);
            else if (r < 9)
                t += $urandom_range(0, 2500);
            else
                t = $urandom;
            r = $urandom_range(0, 99);
            if (r < 45)
                act = (int'($urandom_range(0, 99)) < succ_pct) ? ACT_TX_SUCCESS
                                                                : ACT_TX_FAILURE;
            else if (r < 75)
                act = ACT_STATUS;
            else
                act = ACT_QUALITY;
            queue_event(act, t);
        end
        drain();
    endtask

    initial
    begin : stimulus_proc
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // The link is still disabled after reset, so these change nothing.
        queue_event(ACT_TX_SUCCESS, 32'd5);
        queue_event(ACT_TX_FAILURE, 32'd6);
        queue_event(ACT_STATUS, 32'd7);
        queue_event(ACT_QUALITY, 32'd8);
        drain();

        set_config(1'b1, SUCCESS_WINDOW_RST, FAILURE_WINDOW_RST,
                   STATUS_THRESH_RST, QUALITY_THRESH_RST);
        queue_event(ACT_QUALITY, 32'd0);
        queue_event(ACT_STATUS, 32'd100);
        queue_event(ACT_STATUS, 32'd999);
        queue_event(ACT_STATUS, 32'd1000);
        queue_event(ACT_TX_SUCCESS, 32'hFFFF_FFF0);
        queue_event(ACT_STATUS, 32'h0000_0010);
        queue_event(ACT_QUALITY, 32'h0000_0010);
        queue_event(ACT_TX_FAILURE, 32'hFFFF_FFFF);
        queue_event(ACT_STATUS, 32'd5);
        queue_event(ACT_QUALITY, 32'd5);
        queue_event(ACT_TX_SUCCESS, 32'd1000);
        queue_event(ACT_STATUS, 32'd3000);
        queue_event(ACT_QUALITY, 32'd2999);
        queue_event(ACT_TX_SUCCESS, 32'd3000);
        queue_event(ACT_QUALITY, 32'd4999);
        queue_event(ACT_QUALITY, 32'd5000);
        queue_event(ACT_STATUS, 32'd4999);
        drain();

        random_phase(1'b1, SUCCESS_WINDOW_RST, FAILURE_WINDOW_RST,
                     STATUS_THRESH_RST, QUALITY_THRESH_RST, 1'b1);
        random_phase(1'b1, 16'd0, 16'd0, 9'd0, 9'd0, 1'b0);
        random_phase(1'b1, 16'hFFFF, 16'hFFFF, 9'h1FF, 9'd256, 1'b0);
        random_phase(1'b0, pick_window(), pick_window(),
                     pick_threshold(), pick_threshold(), 1'b0);
        random_phase(1'b1, pick_window(), pick_window(),
                     pick_threshold(), pick_threshold(), 1'b0);
        random_phase(1'b1, pick_window(), pick_window(),
                     pick_threshold(), pick_threshold(), 1'b0);

        // The last phase runs with no idling on either side.
        calm = 1'b1;
        random_phase(1'b1, pick_window(), pick_window(),
                     pick_threshold(), pick_threshold(), 1'b0);

        repeat (8) @(posedge clk);
        if (expected_reports.size() != 0)
        begin
            $error("%0d results never arrived", expected_reports.size());
            fault_count++;
        end
        $display("Checked %0d results for %0d link events over %0d register settings,",
                 results_checked, events_accepted, settings_count);
        $display("with timestamp wrap, window edges, long output hold-off and full rate.");
        if (fault_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
